FILE: src/ilpe_pkg.sv
// ilpe_pkg: characters, widths and the per-line tracking record for the INI line pair extractor
// No dependencies. The position width itself is a parameter of the top level.
package ilpe_pkg;

  localparam int unsigned OUT_W = 16;
  localparam logic [OUT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;

  // characters of a line that are always kept, the rest are positions of POS_BITS
  typedef struct packed {
    logic       has_text;
    logic [7:0] first_char;
    logic [7:0] last_char;
    logic       eq_seen;
    logic       key_has_text;
    logic       val_has_text;
  } line_flags_t;

endpackage

FILE: src/ini_line_pair_extractor.sv
// ini_line_pair_extractor: splits INI text into lines and reports name/value pairs
// Depends on ilpe_pkg for character codes, widths and the line flag record.
// A line's last byte waits in the input register, then loads the result register once
// the result side is free (no result held, or the held one is being taken).
// Throughput: one byte per cycle while the result side takes requests; trackers
// update with compares and adds only. Reset clears all tracking state and the
// valid flags of both stages; the final byte also returns every tracker to its reset value.
module ini_line_pair_extractor #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       final_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ilpe_pkg::OUT_W-1:0] name_offset_o,
  output logic [ilpe_pkg::OUT_W-1:0] name_length_o,
  output logic [ilpe_pkg::OUT_W-1:0] value_offset_o,
  output logic [ilpe_pkg::OUT_W-1:0] value_length_o,
  output logic [ilpe_pkg::OUT_W-1:0] section_offset_o,
  output logic [ilpe_pkg::OUT_W-1:0] section_length_o,
  output logic [ilpe_pkg::OUT_W-1:0] pair_count_o
);

  localparam int unsigned OW = ilpe_pkg::OUT_W;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_fin_q;
  logic       advance;

  // trackers
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] first_pos_q, first_pos_d;
  logic [POS_BITS-1:0] last_pos_q, last_pos_d;
  logic [POS_BITS-1:0] key_last_q, key_last_d;
  logic [POS_BITS-1:0] val_first_q, val_first_d;
  logic [POS_BITS-1:0] eq_pos_q, eq_pos_d;
  logic [POS_BITS-1:0] sec_start_q, sec_start_d;
  logic [POS_BITS-1:0] sec_len_q, sec_len_d;
  logic [OW-1:0]       pairs_q, pairs_d;
  ilpe_pkg::line_flags_t flags_q, flags_d;

  // values after this byte is folded into the line
  logic [POS_BITS-1:0] first_pos_t, last_pos_t, key_last_t, val_first_t, eq_pos_t;
  ilpe_pkg::line_flags_t flags_t;
  logic [POS_BITS-1:0] line_len;
  logic [OW-1:0]       pairs_inc;
  logic is_nl, is_text, is_eq, line_end, usable, is_section, is_pair;

  // result register
  logic          out_vld_q, out_vld_d;
  logic [OW-1:0] name_off_q, name_len_q, val_off_q, val_len_q;
  logic [OW-1:0] sec_off_q, sec_len_out_q, count_q;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= text_byte_i;
      in_fin_q  <= final_byte_i;
    end
  end

  always_comb begin
    is_nl   = in_byte_q == ilpe_pkg::CH_NEWLINE;
    is_text = !is_nl && in_byte_q != ilpe_pkg::CH_SPACE && in_byte_q != ilpe_pkg::CH_TAB;
    is_eq   = in_byte_q == ilpe_pkg::CH_EQUALS;

    flags_t     = flags_q;
    first_pos_t = first_pos_q;
    last_pos_t  = last_pos_q;
    key_last_t  = key_last_q;
    val_first_t = val_first_q;
    eq_pos_t    = eq_pos_q;
    if (is_text) begin
      if (!flags_q.has_text) begin
        flags_t.has_text   = 1'b1;
        flags_t.first_char = in_byte_q;
        first_pos_t        = pos_q;
      end
      flags_t.last_char = in_byte_q;
      last_pos_t        = pos_q;
      if (!flags_q.eq_seen) begin
        if (is_eq) begin
          flags_t.eq_seen = 1'b1;
          eq_pos_t        = pos_q;
        end else begin
          flags_t.key_has_text = 1'b1;
          key_last_t           = pos_q;
        end
      end else if (!flags_q.val_has_text) begin
        flags_t.val_has_text = 1'b1;
        val_first_t          = pos_q;
      end
    end

    line_end = is_nl || in_fin_q;
    line_len = last_pos_t - first_pos_t + POS_ONE;
    usable   = flags_t.has_text && line_len >= POS_TWO
               && flags_t.first_char != ilpe_pkg::CH_HASH
               && flags_t.first_char != ilpe_pkg::CH_SEMI;
    is_section = line_end && usable && flags_t.first_char == ilpe_pkg::CH_LBRACK
                 && flags_t.last_char == ilpe_pkg::CH_RBRACK;
    is_pair    = line_end && usable && !is_section && flags_t.eq_seen
                 && flags_t.key_has_text;
    pairs_inc  = (pairs_q == ilpe_pkg::COUNT_MAX) ? pairs_q : pairs_q + OW'(1);

    pos_d       = pos_q + POS_ONE;
    flags_d     = flags_t;
    first_pos_d = first_pos_t;
    last_pos_d  = last_pos_t;
    key_last_d  = key_last_t;
    val_first_d = val_first_t;
    eq_pos_d    = eq_pos_t;
    sec_start_d = sec_start_q;
    sec_len_d   = sec_len_q;
    pairs_d     = pairs_q;
    if (line_end) begin
      flags_d     = '0;
      first_pos_d = '0;
      last_pos_d  = '0;
      key_last_d  = '0;
      val_first_d = '0;
      eq_pos_d    = '0;
    end
    if (is_section) begin
      sec_start_d = first_pos_t + POS_ONE;
      sec_len_d   = line_len - POS_TWO;
      pairs_d     = '0;
    end
    if (is_pair) begin
      pairs_d = pairs_inc;
    end
    if (in_fin_q) begin
      pos_d       = '0;
      sec_start_d = '0;
      sec_len_d   = '0;
      pairs_d     = '0;
    end

    out_vld_d = out_vld_q && !out_ready_i;
    if (advance) begin
      out_vld_d = is_pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_pos_q <= '0;
      last_pos_q  <= '0;
      key_last_q  <= '0;
      val_first_q <= '0;
      eq_pos_q    <= '0;
      sec_start_q <= '0;
      sec_len_q   <= '0;
      pairs_q     <= '0;
      flags_q     <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (advance) begin
        pos_q       <= pos_d;
        first_pos_q <= first_pos_d;
        last_pos_q  <= last_pos_d;
        key_last_q  <= key_last_d;
        val_first_q <= val_first_d;
        eq_pos_q    <= eq_pos_d;
        sec_start_q <= sec_start_d;
        sec_len_q   <= sec_len_d;
        pairs_q     <= pairs_d;
        flags_q     <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_pair) begin
      name_off_q    <= OW'(first_pos_t);
      name_len_q    <= OW'(POS_BITS'(key_last_t - first_pos_t + POS_ONE));
      // empty value points just past the equals sign
      if (flags_t.val_has_text) begin
        val_off_q <= OW'(val_first_t);
        val_len_q <= OW'(POS_BITS'(last_pos_t - val_first_t + POS_ONE));
      end else begin
        val_off_q <= OW'(POS_BITS'(eq_pos_t + POS_ONE));
        val_len_q <= '0;
      end
      sec_off_q     <= OW'(sec_start_q);
      sec_len_out_q <= OW'(sec_len_q);
      count_q       <= pairs_inc;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign name_offset_o    = name_off_q;
  assign name_length_o    = name_len_q;
  assign value_offset_o   = val_off_q;
  assign value_length_o   = val_len_q;
  assign section_offset_o = sec_off_q;
  assign section_length_o = sec_len_out_q;
  assign pair_count_o     = count_q;

endmodule

FILE: dv/ilpe_pair_checker.sv
// ilpe_pair_checker: watches both channels of ini_line_pair_extractor, predicts each pair
// from the accepted text bytes and compares every result field. Depends on ilpe_pkg.
module ilpe_pair_checker
  import ilpe_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       text_byte_i,
  input  logic             final_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [OUT_W-1:0] name_offset_i,
  input  logic [OUT_W-1:0] name_length_i,
  input  logic [OUT_W-1:0] value_offset_i,
  input  logic [OUT_W-1:0] value_length_i,
  input  logic [OUT_W-1:0] section_offset_i,
  input  logic [OUT_W-1:0] section_length_i,
  input  logic [OUT_W-1:0] pair_count_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned NUM_FIELDS = 7;

  typedef struct packed {
    logic [OUT_W-1:0] name_offset;
    logic [OUT_W-1:0] name_length;
    logic [OUT_W-1:0] value_offset;
    logic [OUT_W-1:0] value_length;
    logic [OUT_W-1:0] section_offset;
    logic [OUT_W-1:0] section_length;
    logic [OUT_W-1:0] pair_count;
  } pair_rec_t;

  string field_names[NUM_FIELDS] = '{"name_offset", "name_length", "value_offset",
                                     "value_length", "section_offset", "section_length",
                                     "pair_count"};

  // line trackers, positions are POS_BITS wide and wrap
  logic [POS_BITS-1:0] byte_pos, first_pos, last_pos, eq_pos, key_last, val_first;
  logic [POS_BITS-1:0] sect_start, sect_len;
  logic [OUT_W-1:0]    pairs_in_sect;
  line_flags_t         flags;

  pair_rec_t   expected_pairs[$];
  pair_rec_t   got, want;
  int unsigned results_seen;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("mismatch: %s", msg);
  endtask

  task automatic clear_line();
    flags     = '0;
    first_pos = '0;
    last_pos  = '0;
    eq_pos    = '0;
    key_last  = '0;
    val_first = '0;
  endtask

  task automatic clear_all();
    clear_line();
    byte_pos      = '0;
    sect_start    = '0;
    sect_len      = '0;
    pairs_in_sect = '0;
  endtask

  // tracks one text byte and queues the pair that a finished line yields
  task automatic track_text_byte(input logic [7:0] c, input logic fin);
    logic [POS_BITS-1:0] p, line_len, name_len, voff, vlen;
    pair_rec_t rec;
    p = byte_pos;
    if (c != CH_NEWLINE && c != CH_SPACE && c != CH_TAB) begin
      if (!flags.has_text) begin
        flags.has_text   = 1'b1;
        flags.first_char = c;
        first_pos        = p;
      end
      last_pos        = p;
      flags.last_char = c;
      if (!flags.eq_seen) begin
        if (c == CH_EQUALS) begin
          flags.eq_seen = 1'b1;
          eq_pos        = p;
        end else begin
          key_last           = p;
          flags.key_has_text = 1'b1;
        end
      end else if (!flags.val_has_text) begin
        val_first          = p;
        flags.val_has_text = 1'b1;
      end
    end
    byte_pos = p + 1'b1;
    if (c == CH_NEWLINE || fin) begin
      line_len = last_pos - first_pos + 1'b1;
      if (flags.has_text && line_len >= POS_BITS'(2) &&
          flags.first_char != CH_HASH && flags.first_char != CH_SEMI) begin
        if (flags.first_char == CH_LBRACK && flags.last_char == CH_RBRACK) begin
          sect_start    = first_pos + 1'b1;
          sect_len      = line_len - POS_BITS'(2);
          pairs_in_sect = '0;
        end else if (flags.eq_seen && flags.key_has_text) begin
          if (pairs_in_sect != COUNT_MAX) pairs_in_sect++;
          name_len = key_last - first_pos + 1'b1;
          if (flags.val_has_text) begin
            voff = val_first;
            vlen = last_pos - val_first + 1'b1;
          end else begin
            voff = eq_pos + 1'b1;
            vlen = '0;
          end
          rec.name_offset    = OUT_W'(first_pos);
          rec.name_length    = OUT_W'(name_len);
          rec.value_offset   = OUT_W'(voff);
          rec.value_length   = OUT_W'(vlen);
          rec.section_offset = OUT_W'(sect_start);
          rec.section_length = OUT_W'(sect_len);
          rec.pair_count     = pairs_in_sect;
          expected_pairs.push_back(rec);
        end
      end
      clear_line();
    end
    if (fin) clear_all();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      expected_pairs.delete();
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) track_text_byte(text_byte_i, final_byte_i);
      if (out_valid_i && out_ready_i) begin
        got = '{name_offset_i, name_length_i, value_offset_i, value_length_i,
                section_offset_i, section_length_i, pair_count_i};
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no pair expected", results_seen));
        end else begin
          want = expected_pairs.pop_front();
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (got[(NUM_FIELDS-1-i)*OUT_W +: OUT_W] !== want[(NUM_FIELDS-1-i)*OUT_W +: OUT_W])
              report_mismatch($sformatf("result %0d %s: got %0d, expected %0d", results_seen,
                field_names[i], got[(NUM_FIELDS-1-i)*OUT_W +: OUT_W],
                want[(NUM_FIELDS-1-i)*OUT_W +: OUT_W]));
          end
        end
        results_seen++;
      end
      pending_o = expected_pairs.size();
    end
  end

endmodule

FILE: dv/ini_line_pair_extractor_tb.sv
// ini_line_pair_extractor_tb: drives INI text into the extractor with random idling on both
// sides and gives the verdict. Depends on ilpe_pkg and the ilpe_pair_checker module.
module ini_line_pair_extractor_tb;
  import ilpe_pkg::*;

  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned RANDOM_BYTES = 380;
  localparam int unsigned BURST_LINES  = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [7:0]       text_byte_i = '0;
  logic             final_byte_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [OUT_W-1:0] name_offset_o, name_length_o, value_offset_o, value_length_o;
  logic [OUT_W-1:0] section_offset_o, section_length_o, pair_count_o;

  int unsigned fail_count, pending_pairs;
  int unsigned cycle_cnt = 0;
  int unsigned bytes_sent = 0;
  bit          full_rate = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  line_q[$];

  always #5 clk_i = ~clk_i;

  ini_line_pair_extractor #(.POS_BITS(POS_BITS)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .text_byte_i, .final_byte_i,
    .out_valid_o, .out_ready_i, .name_offset_o, .name_length_o, .value_offset_o,
    .value_length_o, .section_offset_o, .section_length_o, .pair_count_o
  );

  ilpe_pair_checker #(.POS_BITS(POS_BITS)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .text_byte_i, .final_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .name_offset_i(name_offset_o), .name_length_i(name_length_o),
    .value_offset_i(value_offset_o), .value_length_i(value_length_o),
    .section_offset_i(section_offset_o), .section_length_i(section_length_o),
    .pair_count_i(pair_count_o),
    .fail_count_o(fail_count), .pending_o(pending_pairs)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_char(input bit allow_eq);
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 25) + 'h61);
    do c = 8'($urandom_range(0, 255));
    while (c == CH_NEWLINE || (!allow_eq && c == CH_EQUALS));
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_last && i == s.len() - 1);
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(0, 2)) line_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic add_chars(input int unsigned lo, input int unsigned hi, input bit allow_eq);
    repeat ($urandom_range(lo, hi)) line_q.push_back(rand_char(allow_eq));
  endtask

  task automatic build_pair(input int unsigned max_val);
    add_blanks();
    add_chars(1, 4, 1'b0);
    add_blanks();
    line_q.push_back(CH_EQUALS);
    add_blanks();
    add_chars(0, max_val, 1'b1);
    add_blanks();
  endtask

  // one random line: mostly pairs and sections, some comments, broken lines and noise
  task automatic build_line();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      build_pair(5);
    end else if (kind < 77) begin
      add_blanks();
      line_q.push_back(CH_LBRACK);
      add_chars(0, 4, 1'b1);
      line_q.push_back(CH_RBRACK);
      add_blanks();
    end else if (kind < 83) begin
      add_blanks();
      line_q.push_back($urandom_range(0, 1) ? CH_HASH : CH_SEMI);
      add_chars(0, 3, 1'b0);
      line_q.push_back(CH_EQUALS);
      add_chars(0, 3, 1'b1);
    end else if (kind < 90) begin
      case ($urandom_range(0, 2))
        0: begin
          add_blanks();
          line_q.push_back(CH_EQUALS);
          add_chars(0, 4, 1'b1);
        end
        1: add_chars(0, 5, 1'b0);
        default: begin
          line_q.push_back(CH_LBRACK);
          add_chars(0, 4, 1'b1);
        end
      endcase
    end else begin
      repeat ($urandom_range(0, 6)) line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // sends the built line, ending it with a newline or marking a byte final
  task automatic send_line(input bit allow_final);
    int unsigned ending;
    ending = allow_final ? $urandom_range(0, 19) : 2;
    if (ending != 0 || line_q.size() == 0) line_q.push_back(CH_NEWLINE);
    for (int i = 0; i < line_q.size(); i++)
      send_byte(line_q[i], ending <= 1 && i == line_q.size() - 1);
    line_q.delete();
  endtask

  // result side: random stalls, one long hold on request, none at full rate
  initial begin
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (full_rate) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        int unsigned gap;
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned start_bytes;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines
    send_text("a=1\n", 1'b0);
    send_text(" \tkey \t=\t val \t\n", 1'b0);
    send_text("x=\n", 1'b0);
    send_text("x =  \n", 1'b0);
    send_text("=v\n", 1'b0);
    send_text("#a=b\n", 1'b0);
    send_text(";a=b\n", 1'b0);
    send_text("noeq\n", 1'b0);
    send_text("k\n", 1'b0);
    send_text("\n", 1'b0);
    send_text(" \t \n", 1'b0);
    send_text("[sec]\n", 1'b0);
    send_text("p=q\n", 1'b0);
    send_text("[]\n", 1'b0);
    send_text("r=s\n", 1'b0);
    send_text("[a=b]\n", 1'b0);
    send_text("[x\n", 1'b0);
    send_text("[y=1\n", 1'b0);
    send_text("k=a=b\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_EQUALS, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h0d, 1'b0);
    send_byte(CH_NEWLINE, 1'b0);
    send_text("q=z", 1'b1);
    send_text("r=s\n", 1'b1);
    send_text("u=v\n", 1'b0);
    send_text(" ", 1'b1);
    send_text("#", 1'b1);

    // short burst with no gaps on either side
    full_rate = 1'b1;
    send_text("[s]\n", 1'b0);
    for (int unsigned i = 0; i < BURST_LINES; i++) begin
      if (i % 4 == 0) begin
        build_pair(8);
        send_line(1'b0);
      end else begin
        send_text("a=\n", 1'b0);
      end
    end
    send_text("end=1", 1'b1);
    full_rate = 1'b0;

    // random lines, starting with a long stall of the result side
    hold_req    = 1'b1;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      build_line();
      send_line(1'b1);
    end
    in_valid_i <= 1'b0;

    do @(negedge clk_i); while (pending_pairs != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_pairs == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
src/ilpe_pkg.sv
src/ini_line_pair_extractor.sv
dv/ilpe_pair_checker.sv
dv/ini_line_pair_extractor_tb.sv
